@@ src/ocla_pkg.sv @@
// Shared types, codes and constants of the overlay comment lane allocator.
package ocla_pkg;

    // Field widths of the stream payloads.
    localparam int TIME_IN_W  = 32;
    localparam int KIND_W     = 2;
    localparam int WIDTH_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int LANE_OUT_W = 6;
    localparam int Y_W        = 16;
    localparam int TIME_OUT_W = 40;
    localparam int ENDX_W     = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_LANE_COUNT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MS_PER_PIXEL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIDE_MASK    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_OFFSET  = 3'd4;

    // Comment kinds; the fourth code is placed as a scroll comment.
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOTTOM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALT    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HIDDEN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    // Lane table selects.
    localparam logic [1:0] TAB_SCROLL = 2'd0;
    localparam logic [1:0] TAB_TOP    = 2'd1;
    localparam logic [1:0] TAB_BOTTOM = 2'd2;

    // Timing and geometry constants.
    localparam int STATIC_DURATION  = 4200;
    localparam int STATIC_MAX_DELAY = 1800;
    localparam int SCROLL_MIN_DUR   = 2200;
    localparam int SCROLL_MAX_DUR   = 22000;
    localparam int SCROLL_MIN_DELAY = 300;
    localparam int SCROLL_BASE_DIST = 6000;
    localparam int SCROLL_END_PAD   = 144;
    localparam int SCROLL_GAP_PAD   = 288;
    localparam int DELAY_NUM        = 42;
    localparam int DELAY_ROUND      = 49;
    localparam int DELAY_DEN        = 100;
    localparam int TOP_Y            = 72;
    localparam int BOTTOM_Y         = 3096;
    localparam int HALF_LSB         = 32768;
    localparam int FULL_LSB         = 65535;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 23;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_DUR,
        ST_MUL_GAP,
        ST_SCAN_GO,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_CHECK,
        ST_MUL_Y,
        ST_COMMIT,
        ST_OUT
    } state_t;

    // Request from the sequencer to the lane table scanner.
    typedef struct packed {
        logic       start;
        logic [1:0] tab;
    } scan_req_t;

endpackage

@@ src/ocla_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ocla_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 192
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ocla_lane_table.sv @@
// Three lane tables of free-from times and the lane scanner that searches them.
module ocla_lane_table import ocla_pkg::*; #(
    parameter int MAX_LANES = 64,
    parameter int TIME_BITS = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scan_req_t            scan_req,
    input  logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] n_last,
    input  logic [TIME_BITS-1:0] start_time,
    input  logic                 wr_en,
    input  logic [1:0]           wr_tab,
    input  logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] wr_lane,
    input  logic [TIME_BITS-1:0] wr_data,
    output logic                 done,
    output logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] sel_lane,
    output logic [TIME_BITS-1:0] sel_time
);

    localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int AW     = LANE_W + 2;
    localparam int DEPTH  = 3 << LANE_W;

    logic [1:0]           tab_reg;
    logic                 issue_reg;
    logic                 dval_reg;
    logic                 done_reg;
    logic                 vq_reg;
    logic [LANE_W-1:0]    rd_idx_reg;
    logic [LANE_W-1:0]    didx_reg;
    logic [LANE_W-1:0]    best_idx_reg;
    logic [LANE_W-1:0]    sel_idx_reg;
    logic [TIME_BITS-1:0] best_t_reg;
    logic [TIME_BITS-1:0] sel_t_reg;
    logic [DEPTH-1:0]     vld_reg;
    logic [TIME_BITS-1:0] rdata;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [TIME_BITS-1:0] entry;
    logic                 hit;
    logic                 last;
    logic                 finish;
    logic                 take_new;
    logic [TIME_BITS-1:0] nb_t;
    logic [LANE_W-1:0]    nb_idx;

    assign raddr = {tab_reg, rd_idx_reg};
    assign waddr = {wr_tab, wr_lane};

    // Table storage; through the valid bits, entries that were never written count as zero.
    ocla_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wr_data),
        .re    (issue_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Compare the entry that just came back against the start time and the running minimum.
    always_comb begin
        entry    = vq_reg ? rdata : '0;
        hit      = dval_reg && (entry <= start_time);
        last     = dval_reg && (didx_reg == n_last);
        finish   = hit || last;
        take_new = (didx_reg == '0) || (entry < best_t_reg);
        nb_t     = take_new ? entry : best_t_reg;
        nb_idx   = take_new ? didx_reg : best_idx_reg;
    end

    // Scan control and valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg  <= 1'b0;
            dval_reg   <= 1'b0;
            done_reg   <= 1'b0;
            rd_idx_reg <= '0;
            vld_reg    <= '0;
        end else begin
            done_reg <= finish;
            if (scan_req.start) begin
                issue_reg  <= 1'b1;
                dval_reg   <= 1'b0;
                rd_idx_reg <= '0;
            end else begin
                dval_reg <= issue_reg && !finish;
                if (finish) begin
                    issue_reg <= 1'b0;
                end else if (issue_reg) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_idx_reg == n_last) begin
                        issue_reg <= 1'b0;
                    end
                end
            end
            if (wr_en) begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    // Scan payload: read tags, running minimum and the chosen lane.
    always_ff @(posedge aclk) begin
        if (scan_req.start) begin
            tab_reg <= scan_req.tab;
        end
        if (issue_reg) begin
            didx_reg <= rd_idx_reg;
            vq_reg   <= vld_reg[raddr];
        end
        if (dval_reg) begin
            best_t_reg   <= nb_t;
            best_idx_reg <= nb_idx;
        end
        if (finish) begin
            sel_idx_reg <= hit ? didx_reg : nb_idx;
            sel_t_reg   <= hit ? entry : nb_t;
        end
    end

    assign done     = done_reg;
    assign sel_lane = sel_idx_reg;
    assign sel_time = sel_t_reg;

endmodule

@@ src/overlay_comment_lane_allocator.sv @@
// Top level: sequencer, shared multiplier, configuration and stream ports.
//
// Each input transfer carries one comment: time_ms and text_width in s_tdata,
// the comment kind in s_tuser. The block answers every comment with exactly
// one result transfer: status in m_tuser, lane, y position, start and end
// time and final scroll x in m_tdata. Hidden and dropped comments return
// their status with all other fields zero and leave the lane tables alone.
// One comment is handled at a time; s_tready is high only while the
// sequencer waits for a new comment. A scroll comment first goes through
// the shared multiplier for its duration and then its lane gap. The lane
// scan then reads one table entry per cycle and stops at the first free
// lane. Deciding, the overload check, one more multiply for the y position
// and the table write follow; the sequencer is ready for the next comment
// in the same cycle that m_tvalid rises. The result waits in an output
// register; when the receiver stalls the block still takes and works on the
// next comment and holds it only when its own result is ready. Reset clears
// all lane tables (valid bits) and loads the register defaults at once.
module overlay_comment_lane_allocator import ocla_pkg::*; #(
    parameter int MAX_LANES = 64,
    parameter int TIME_BITS = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: [31:0] time_ms, [47:32] text_width
    input  logic [47:0]            s_tdata,
    // s_tuser: [1:0] kind
    input  logic [KIND_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: [5:0] lane, [21:6] y_pos, [61:22] start_ms, [101:62] end_ms,
    // [119:102] end_x
    output logic [119:0]           m_tdata,
    // m_tuser: [1:0] status
    output logic [STATUS_W-1:0]    m_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

    // Configuration registers.
    logic [6:0]  lane_count_reg;
    logic [9:0]  line_height_reg;
    logic [22:0] ms_per_pixel_reg;
    logic [2:0]  hide_mask_reg;
    logic [31:0] time_offset_reg;

    // Sequencer and item registers.
    state_t                state_reg, state_next;
    logic [TIME_IN_W-1:0]  t_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [WIDTH_W-1:0]    w_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [TIME_BITS-1:0]  actual_reg;
    logic [14:0]           dur_reg;
    logic [24:0]           gap_reg;
    logic [MUL_P_W-1:0]    prod_reg;

    // Result of the current comment, then the output register.
    logic [STATUS_W-1:0]   res_status_reg;
    logic [LANE_OUT_W-1:0] res_lane_reg;
    logic [Y_W-1:0]        res_y_reg;
    logic [TIME_OUT_W-1:0] res_start_reg;
    logic [TIME_OUT_W-1:0] res_end_reg;
    logic [ENDX_W-1:0]     res_endx_reg;
    logic                  m_valid_reg;
    logic [119:0]          m_data_reg;
    logic [STATUS_W-1:0]   m_user_reg;

    // Control from the output logic.
    logic                  accept;
    logic                  mul_en;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic                  wr_en;
    logic                  out_free;
    logic                  out_load;
    scan_req_t             scan_req;

    // Datapath signals.
    logic                  is_static;
    logic                  hidden;
    logic [1:0]            tab;
    logic [33:0]           time_sum;
    logic [TIME_BITS-1:0]  start_calc;
    logic [MUL_P_W:0]      dur_sum;
    logic [MUL_P_W:0]      gap_sum;
    logic [24:0]           dur_raw;
    logic [14:0]           dur_clamped;
    logic [TIME_BITS-1:0]  delay;
    logic [20:0]           delay_lim;
    logic [26:0]           delay_x100;
    logic                  drop;
    logic [19:0]           y_top;
    logic signed [19:0]    y_bot;
    logic [Y_W-1:0]        y_sat;
    logic [TIME_BITS-1:0]  end_time;
    logic [TIME_BITS-1:0]  free_time;
    logic [8:0]            lc_ext;
    logic [8:0]            n_lanes;
    logic [LANE_W-1:0]     n_last;
    logic                  scan_done;
    logic [LANE_W-1:0]     sel_lane;
    logic [TIME_BITS-1:0]  sel_time;

    // Number of active lanes: zero acts as one, large values stop at the table size.
    always_comb begin
        lc_ext = 9'(lane_count_reg);
        if (lc_ext == 9'd0) begin
            n_lanes = 9'd1;
        end else if (lc_ext > 9'(MAX_LANES)) begin
            n_lanes = 9'(MAX_LANES);
        end else begin
            n_lanes = lc_ext;
        end
        n_last = LANE_W'(n_lanes - 9'd1);
    end

    // Kind decoding.
    always_comb begin
        is_static = (kind_reg == KIND_TOP) || (kind_reg == KIND_BOTTOM);
        hidden    = (kind_reg != KIND_ALT) && hide_mask_reg[kind_reg];
        case (kind_reg)
            KIND_TOP:    tab = TAB_TOP;
            KIND_BOTTOM: tab = TAB_BOTTOM;
            default:     tab = TAB_SCROLL;
        endcase
    end

    // Start time: timestamp plus signed offset, negative results become zero.
    always_comb begin
        time_sum   = {2'b00, t_reg} + {{2{time_offset_reg[31]}}, time_offset_reg};
        start_calc = time_sum[33] ? '0 : TIME_BITS'(time_sum[32:0]);
    end

    // Duration and lane gap from the multiplier product.
    always_comb begin
        dur_sum = (MUL_P_W + 1)'(prod_reg) + (MUL_P_W + 1)'(HALF_LSB);
        gap_sum = (MUL_P_W + 1)'(prod_reg) + (MUL_P_W + 1)'(FULL_LSB);
        dur_raw = dur_sum[MUL_P_W:16];
        if (dur_raw < 25'(SCROLL_MIN_DUR)) begin
            dur_clamped = 15'(SCROLL_MIN_DUR);
        end else if (dur_raw > 25'(SCROLL_MAX_DUR)) begin
            dur_clamped = 15'(SCROLL_MAX_DUR);
        end else begin
            dur_clamped = dur_raw[14:0];
        end
    end

    // Overload test. For scroll comments the wait limit is 0.42 of the duration,
    // rounded and at least 300; delay > floor(x / 100) is tested as 100 * delay > x.
    always_comb begin
        delay      = actual_reg - start_reg;
        delay_lim  = 21'(dur_reg) * 21'(DELAY_NUM) + 21'(DELAY_ROUND);
        delay_x100 = 27'(delay[19:0]) * 27'(DELAY_DEN);
        if (is_static) begin
            drop = delay > TIME_BITS'(STATIC_MAX_DELAY);
        end else begin
            drop = (delay > TIME_BITS'(SCROLL_MIN_DELAY))
                && ((|delay[TIME_BITS-1:20]) || (delay_x100 > 27'(delay_lim)));
        end
    end

    // Lane position and end times.
    always_comb begin
        y_top = 20'(TOP_Y) + {2'b00, prod_reg[17:0]};
        y_bot = 20'(BOTTOM_Y) - $signed({2'b00, prod_reg[17:0]});
        if (kind_reg == KIND_BOTTOM) begin
            y_sat = (y_bot < -20'sd32768) ? 16'h8000 : y_bot[15:0];
        end else begin
            y_sat = (y_top > 20'd32767) ? 16'h7FFF : y_top[15:0];
        end
        if (is_static) begin
            end_time  = actual_reg + TIME_BITS'(STATIC_DURATION);
            free_time = end_time;
        end else begin
            end_time  = actual_reg + TIME_BITS'(dur_reg);
            free_time = actual_reg + TIME_BITS'(gap_reg);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_PREP;
            ST_PREP: begin
                if (hidden) begin
                    state_next = ST_OUT;
                end else if (is_static) begin
                    state_next = ST_SCAN_GO;
                end else begin
                    state_next = ST_MUL_DUR;
                end
            end
            ST_MUL_DUR:   state_next = ST_MUL_GAP;
            ST_MUL_GAP:   state_next = ST_SCAN_GO;
            ST_SCAN_GO:   state_next = ST_SCAN_WAIT;
            ST_SCAN_WAIT: if (scan_done) state_next = ST_DECIDE;
            ST_DECIDE:    state_next = ST_CHECK;
            ST_CHECK:     state_next = drop ? ST_OUT : ST_MUL_Y;
            ST_MUL_Y:     state_next = ST_COMMIT;
            ST_COMMIT:    state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready       = 1'b0;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        wr_en          = 1'b0;
        out_free       = !m_valid_reg || m_tready;
        out_load       = 1'b0;
        scan_req.start = 1'b0;
        scan_req.tab   = tab;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_MUL_DUR: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(w_reg) + MUL_A_W'(SCROLL_BASE_DIST);
                mul_b  = ms_per_pixel_reg;
            end
            ST_MUL_GAP: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(w_reg) + MUL_A_W'(SCROLL_GAP_PAD);
                mul_b  = ms_per_pixel_reg;
            end
            ST_SCAN_GO: scan_req.start = 1'b1;
            ST_MUL_Y: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(sel_lane);
                mul_b  = MUL_B_W'(line_height_reg);
            end
            ST_COMMIT:  wr_en = 1'b1;
            ST_OUT:     out_load = out_free;
            default:    ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Lane tables and scanner.
    ocla_lane_table #(
        .MAX_LANES (MAX_LANES),
        .TIME_BITS (TIME_BITS)
    ) u_lane_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_req   (scan_req),
        .n_last     (n_last),
        .start_time (start_reg),
        .wr_en      (wr_en),
        .wr_tab     (tab),
        .wr_lane    (sel_lane),
        .wr_data    (free_time),
        .done       (scan_done),
        .sel_lane   (sel_lane),
        .sel_time   (sel_time)
    );

    // Control state, configuration and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            lane_count_reg   <= 7'd1;
            line_height_reg  <= 10'd169;
            ms_per_pixel_reg <= 23'd65536;
            hide_mask_reg    <= 3'd0;
            time_offset_reg  <= 32'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_LANE_COUNT:   lane_count_reg   <= cfg_wdata[6:0];
                    REG_LINE_HEIGHT:  line_height_reg  <= cfg_wdata[9:0];
                    REG_MS_PER_PIXEL: ms_per_pixel_reg <= cfg_wdata[22:0];
                    REG_HIDE_MASK:    hide_mask_reg    <= cfg_wdata[2:0];
                    REG_TIME_OFFSET:  time_offset_reg  <= cfg_wdata;
                    default:          ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath.
    always_ff @(posedge aclk) begin
        if (accept) begin
            t_reg    <= s_tdata[31:0];
            kind_reg <= s_tuser;
            w_reg    <= (s_tdata[47:32] == '0) ? 16'd1 : s_tdata[47:32];
        end
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (state_reg)
            ST_PREP: begin
                start_reg      <= start_calc;
                res_status_reg <= hidden ? STATUS_HIDDEN : STATUS_PLACED;
                res_lane_reg   <= '0;
                res_y_reg      <= '0;
                res_start_reg  <= '0;
                res_end_reg    <= '0;
                res_endx_reg   <= '0;
            end
            ST_MUL_GAP: dur_reg <= dur_clamped;
            ST_DECIDE: begin
                gap_reg    <= gap_sum[MUL_P_W:16];
                actual_reg <= (sel_time > start_reg) ? sel_time : start_reg;
            end
            ST_CHECK: begin
                if (drop) begin
                    res_status_reg <= STATUS_DROPPED;
                end
            end
            ST_COMMIT: begin
                res_lane_reg  <= LANE_OUT_W'(sel_lane);
                res_y_reg     <= y_sat;
                res_start_reg <= TIME_OUT_W'(actual_reg);
                res_end_reg   <= TIME_OUT_W'(end_time);
                res_endx_reg  <= is_static ? '0
                    : ENDX_W'(0) - ENDX_W'(w_reg) - ENDX_W'(SCROLL_END_PAD);
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg <= {res_endx_reg, res_end_reg, res_start_reg, res_y_reg, res_lane_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ tb/tb_overlay_comment_lane_allocator.sv @@
// Self-checking testbench for the overlay comment lane allocator: random and directed comments.
module tb_overlay_comment_lane_allocator import ocla_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Timing and geometry of the lane placement rules.
    localparam longint unsigned STATIC_LIFE      = 4200;
    localparam longint unsigned STATIC_SLACK     = 1800;
    localparam longint unsigned SCROLL_SHORTEST  = 2200;
    localparam longint unsigned SCROLL_LONGEST   = 22000;
    localparam longint unsigned SCROLL_SLACK_MIN = 300;
    localparam longint unsigned TRAVEL_BASE      = 6000;
    localparam longint unsigned SPACING_PX       = 288;
    localparam longint          TRAIL_PX         = 144;
    localparam longint          TOP_ROW          = 72;
    localparam longint          BOTTOM_ROW       = 3096;
    localparam int              LANE_SLOTS       = 64;
    localparam int              STALL_LIMIT      = 5000;
    localparam int              SETTLE_CYCLES    = 80;
    localparam int              LONG_HOLD        = 400;

    typedef struct {
        logic [31:0] time_ms;
        logic [1:0]  kind;
        logic [15:0] width;
    } comment_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  lane;
        logic [15:0] y_pos;
        logic [39:0] start_ms;
        logic [39:0] end_ms;
        logic [17:0] end_x;
    } placement_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // s_tdata: [31:0] time_ms, [47:32] text_width
    logic [47:0]           s_tdata   = '0;
    // s_tuser: [1:0] kind
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // m_tdata: [5:0] lane, [21:6] y_pos, [61:22] start_ms, [101:62] end_ms, [119:102] end_x
    logic [119:0]          m_tdata;
    // m_tuser: [1:0] status
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the registers and the three lane tables.
    logic [6:0]  cfg_lanes;
    logic [9:0]  cfg_lh;
    logic [22:0] cfg_mpp;
    logic [2:0]  cfg_mask;
    logic [31:0] cfg_off;
    logic [39:0] free_at [3][LANE_SLOTS];

    comment_t   comments_to_send[$];
    placement_t awaited_placements[$];

    logic took_item = 1'b0;
    bit   jitter_on = 1'b1;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   long_hold = 0;
    bit   long_hold_done = 1'b0;
    int   quiet_cycles = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   n_placed = 0;
    int   n_hidden = 0;
    int   n_dropped = 0;
    int   n_settings = 1;

    overlay_comment_lane_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // First lane free by the start time, else the one that frees up earliest.
    function automatic int pick_lane(int tab, logic [39:0] start);
        int n;
        int best;
        n = (cfg_lanes == 0) ? 1
            : ((cfg_lanes > LANE_SLOTS) ? LANE_SLOTS : int'(cfg_lanes));
        best = 0;
        for (int i = 0; i < n; i++) begin
            if (free_at[tab][i] <= start) return i;
            if (free_at[tab][i] < free_at[tab][best]) best = i;
        end
        return best;
    endfunction

    // Placement of one comment; updates the lane table when it is placed.
    function automatic placement_t place_comment(logic [31:0] t, logic [1:0] kind,
                                                 logic [15:0] w_raw);
        placement_t r;
        longint s;
        longint y;
        longint xe;
        logic [39:0] start;
        logic [39:0] actual;
        longint unsigned w;
        longint unsigned dur;
        longint unsigned gap;
        longint unsigned maxd;
        int tab;
        int lane;
        r = '0;
        if (kind != KIND_ALT && cfg_mask[kind]) begin
            r.status = STATUS_HIDDEN;
            return r;
        end
        s = longint'({32'd0, t}) + longint'($signed(cfg_off));
        if (s < 0) s = 0;
        start = s[39:0];
        tab = (kind == KIND_TOP) ? int'(TAB_TOP)
            : ((kind == KIND_BOTTOM) ? int'(TAB_BOTTOM) : int'(TAB_SCROLL));
        w = (w_raw == 0) ? 1 : w_raw;
        if (tab == TAB_SCROLL) begin
            dur = ((TRAVEL_BASE + w) * cfg_mpp + 32768) >> 16;
            if (dur < SCROLL_SHORTEST) dur = SCROLL_SHORTEST;
            if (dur > SCROLL_LONGEST) dur = SCROLL_LONGEST;
            gap = ((w + SPACING_PX) * cfg_mpp + 65535) >> 16;
            maxd = (dur * 42 + 49) / 100;
            if (maxd < SCROLL_SLACK_MIN) maxd = SCROLL_SLACK_MIN;
        end else begin
            dur = STATIC_LIFE;
            gap = STATIC_LIFE;
            maxd = STATIC_SLACK;
        end
        lane = pick_lane(tab, start);
        actual = (free_at[tab][lane] > start) ? free_at[tab][lane] : start;
        if (actual - start > maxd) begin
            r.status = STATUS_DROPPED;
            return r;
        end
        free_at[tab][lane] = actual + gap;
        if (tab == TAB_BOTTOM) y = BOTTOM_ROW - longint'(lane) * longint'(cfg_lh);
        else y = TOP_ROW + longint'(lane) * longint'(cfg_lh);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        r.status = STATUS_PLACED;
        r.lane = lane[5:0];
        r.y_pos = y[15:0];
        r.start_ms = actual;
        r.end_ms = actual + dur;
        if (tab == TAB_SCROLL) begin
            xe = -longint'(w) - TRAIL_PX;
            r.end_x = xe[17:0];
        end
        return r;
    endfunction

    function automatic void send_comment(logic [1:0] kind, logic [31:0] t, logic [15:0] w);
        comment_t c;
        c.time_ms = t;
        c.kind = kind;
        c.width = w;
        comments_to_send.push_back(c);
    endfunction

    // One register write, mirrored into the predictor copy.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_LANE_COUNT:   cfg_lanes = value[6:0];
            REG_LINE_HEIGHT:  cfg_lh = value[9:0];
            REG_MS_PER_PIXEL: cfg_mpp = value[22:0];
            REG_HIDE_MASK:    cfg_mask = value[2:0];
            REG_TIME_OFFSET:  cfg_off = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued comment has gone in and every result has come out.
    task automatic drain();
        while (comments_to_send.size() != 0 || s_tvalid || awaited_placements.size() != 0)
            @(posedge aclk);
    endtask

    // Sender: offers queued comments, with random bursts of idle cycles.
    always @(negedge aclk) begin
        comment_t c;
        if (aresetn && (!s_tvalid || took_item)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else if (comments_to_send.size() != 0) begin
                c = comments_to_send.pop_front();
                s_tdata <= {c.width, c.time_ms};
                s_tuser <= c.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that fills the block up.
    always @(negedge aclk) begin
        if (long_hold > 0) begin
            long_hold--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1'b1;
            long_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (jitter_on && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Predict on each input transfer, check each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        placement_t got;
        placement_t want;
        if (aresetn) begin
            took_item <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                awaited_placements.push_back(place_comment(s_tdata[31:0], s_tuser,
                                                           s_tdata[47:32]));
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.lane = m_tdata[5:0];
                got.y_pos = m_tdata[21:6];
                got.start_ms = m_tdata[61:22];
                got.end_ms = m_tdata[101:62];
                got.end_x = m_tdata[119:102];
                results_seen++;
                case (got.status)
                    STATUS_PLACED:  n_placed++;
                    STATUS_HIDDEN:  n_hidden++;
                    STATUS_DROPPED: n_dropped++;
                    default: ;
                endcase
                if (awaited_placements.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing pending (status %0d)",
                                 results_seen, got.status);
                end else begin
                    want = awaited_placements.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result %0d expected: status %0d lane %0d y %0d",
                                      " start %0d end %0d x %0d"},
                                     results_seen, want.status, want.lane, $signed(want.y_pos),
                                     want.start_ms, want.end_ms, $signed(want.end_x));
                            $display({"result %0d actual:   status %0d lane %0d y %0d",
                                      " start %0d end %0d x %0d"},
                                     results_seen, got.status, got.lane, $signed(got.y_pos),
                                     got.start_ms, got.end_ms, $signed(got.end_x));
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("No transfer for %0d cycles, giving up.", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus sequence: directed corners, then random phases under different settings.
    initial begin
        int spread;
        int count;
        int pick;
        logic [31:0] clock_ms;
        logic [31:0] t;
        logic [15:0] w;
        logic [1:0] kind;

        cfg_lanes = 7'd1;
        cfg_lh = 10'd169;
        cfg_mpp = 23'd65536;
        cfg_mask = 3'd0;
        cfg_off = 32'd0;
        foreach (free_at[i, j]) free_at[i][j] = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default settings: one lane, delays up to and past the static limit.
        send_comment(KIND_TOP, 32'd0, 16'd1);
        send_comment(KIND_TOP, 32'd1000, 16'd1);
        send_comment(KIND_TOP, 32'd2400, 16'd1);
        send_comment(KIND_BOTTOM, 32'd0, 16'hFFFF);
        send_comment(KIND_BOTTOM, 32'd4201, 16'd7);
        send_comment(KIND_SCROLL, 32'd0, 16'd0);
        send_comment(KIND_SCROLL, 32'd0, 16'd1);
        send_comment(KIND_SCROLL, 32'd0, 16'hFFFF);
        send_comment(KIND_ALT, 32'd10000, 16'd500);
        send_comment(KIND_ALT, 32'd100000, 16'd500);
        send_comment(KIND_SCROLL, 32'hFFFF_FFFF, 16'hFFFF);
        send_comment(KIND_TOP, 32'hFFFF_FFFF, 16'd1);
        send_comment(KIND_BOTTOM, 32'hFFFF_FFFF, 16'h8000);
        drain();

        // Every kind hidden except the fourth code.
        write_reg(REG_HIDE_MASK, 32'd7);
        n_settings++;
        send_comment(KIND_SCROLL, 32'd5, 16'd40);
        send_comment(KIND_TOP, 32'd5, 16'd40);
        send_comment(KIND_BOTTOM, 32'd5, 16'd40);
        send_comment(KIND_ALT, 32'd5, 16'd40);
        drain();

        // Zero time per pixel: minimum duration and no gap between comments.
        write_reg(REG_HIDE_MASK, 32'd0);
        write_reg(REG_MS_PER_PIXEL, 32'd0);
        write_reg(REG_TIME_OFFSET, 32'h0010_0000);
        n_settings++;
        send_comment(KIND_SCROLL, 32'hFFFF_FFFF, 16'd1000);
        send_comment(KIND_SCROLL, 32'hFFFF_FFFF, 16'd1000);
        drain();

        // Random phases, mostly time-ordered comment streams.
        for (int p = 1; p <= 6; p++) begin
            drain();
            count = 300;
            clock_ms = $urandom_range(0, 10000);
            case (p)
                1: begin
                    write_reg(REG_LANE_COUNT, 32'd4);
                    write_reg(REG_LINE_HEIGHT, 32'd169);
                    write_reg(REG_MS_PER_PIXEL, 32'd65536);
                    write_reg(REG_HIDE_MASK, 32'd0);
                    write_reg(REG_TIME_OFFSET, 32'd0);
                    spread = 2000;
                end
                2: begin
                    write_reg(REG_LANE_COUNT, 32'd1);
                    write_reg(REG_LINE_HEIGHT, 32'd1);
                    write_reg(REG_MS_PER_PIXEL, 32'd58514);
                    write_reg(REG_HIDE_MASK, 32'd2);
                    write_reg(REG_TIME_OFFSET, 32'hFFFF_FC18);
                    spread = 3000;
                end
                3: begin
                    write_reg(REG_LANE_COUNT, 32'd64);
                    write_reg(REG_LINE_HEIGHT, 32'd1023);
                    write_reg(REG_MS_PER_PIXEL, 32'd6553600);
                    write_reg(REG_HIDE_MASK, 32'd0);
                    write_reg(REG_TIME_OFFSET, 32'h7FFF_FFFF);
                    clock_ms = $urandom;
                    spread = 120;
                end
                4: begin
                    write_reg(REG_LANE_COUNT, 32'd0);
                    write_reg(REG_LINE_HEIGHT, 32'd512);
                    write_reg(REG_MS_PER_PIXEL, 32'd0);
                    write_reg(REG_HIDE_MASK, 32'd5);
                    write_reg(REG_TIME_OFFSET, 32'h8000_0000);
                    clock_ms = 32'h7FFF_C000;
                    spread = 1500;
                end
                5: begin
                    write_reg(REG_LANE_COUNT, 32'd127);
                    write_reg(REG_LINE_HEIGHT, 32'd300);
                    write_reg(REG_MS_PER_PIXEL, 32'h007F_FFFF);
                    write_reg(REG_HIDE_MASK, 32'd4);
                    write_reg(REG_TIME_OFFSET, $urandom);
                    spread = 4000;
                end
                default: begin
                    write_reg(REG_LANE_COUNT, $urandom_range(2, 16));
                    write_reg(REG_LINE_HEIGHT, $urandom_range(1, 512));
                    write_reg(REG_MS_PER_PIXEL, $urandom_range(58514, 200000));
                    write_reg(REG_HIDE_MASK, 32'd0);
                    write_reg(REG_TIME_OFFSET, $urandom_range(0, 100000));
                    jitter_on = 1'b0;
                    spread = 800;
                    count = 130;
                end
            endcase
            n_settings++;

            for (int k = 0; k < count; k++) begin
                pick = $urandom_range(0, 15);
                if (pick < 7) kind = KIND_SCROLL;
                else if (pick < 11) kind = KIND_TOP;
                else if (pick < 14) kind = KIND_BOTTOM;
                else kind = KIND_ALT;

                pick = $urandom_range(0, 15);
                if (pick == 0) w = 16'd0;
                else if (pick == 1) w = 16'hFFFF - 16'($urandom_range(0, 15));
                else if (pick < 4) w = 16'($urandom);
                else w = 16'($urandom_range(1, 2500));

                // A few comments far off the stream or out of order.
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    t = $urandom;
                end else if (pick == 2) begin
                    t = clock_ms - $urandom_range(0, 6000);
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, spread);
                    t = clock_ms;
                end
                send_comment(kind, t, w);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        mismatches += awaited_placements.size();

        $display("Checked %0d results over %0d register settings:",
                 results_seen, n_settings);
        $display("%0d placed, %0d hidden, %0d dropped; a %0d-cycle receiver hold-off; %0d failures.",
                 n_placed, n_hidden, n_dropped, LONG_HOLD, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/ocla_pkg.sv
src/ocla_ram.sv
src/ocla_lane_table.sv
src/overlay_comment_lane_allocator.sv
tb/tb_overlay_comment_lane_allocator.sv
